// ===== hw/rtl/wait_graph_cycle_detector_top_defines.svh =====
// assertion macros for the wait graph cycle detector
`ifndef WAIT_GRAPH_CYCLE_DETECTOR_TOP_DEFINES_SVH
`define WAIT_GRAPH_CYCLE_DETECTOR_TOP_DEFINES_SVH

`ifndef SYNTH
`define WGCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define WGCD_ASSERT_RST_LOW(lbl, sig, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> !(sig)) else $error(msg);
`else
`define WGCD_ASSERT(lbl, prop, msg)
`define WGCD_ASSERT_RST_LOW(lbl, sig, msg)
`endif

`endif

// ===== hw/rtl/wgcd_pkg.sv =====
package wgcd_pkg;

    localparam int NODE_W = 5;
    localparam int CNT_W  = 6;
    localparam int MEMB_W = 32;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_DETECT = 2'd2
    } t_req;

    typedef struct packed {
        logic adj_add;
        logic adj_clr;
        logic run_start;
        logic root_skip;
        logic push_root;
        logic push_nb;
        logic start_walk;
        logic walk_rd;
        logic walk_chk;
        logic save;
        logic pop;
        logic top_load;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic root_done;
        logic root_fin;
        logic cand_none;
        logic cand_unvis;
        logic walk_hit;
        logic depth_one;
        logic out_free;
        logic save_ok;
        logic pend_v;
    } t_sts;

endpackage

// ===== hw/rtl/wgcd_if.sv =====
interface wgcd_req_if;
    import wgcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;

    modport source(output valid, req_type, src_node, dst_node, input ready);
    modport sink(input valid, req_type, src_node, dst_node, output ready);
endinterface

interface wgcd_res_if;
    import wgcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CNT_W-1:0]  cycle_number;
    logic [MEMB_W-1:0] cycle_members;
    logic [NODE_W-1:0] closing_node;
    logic              found;
    logic              last;

    modport source(output valid, cycle_number, cycle_members, closing_node, found, last,
                   input ready);
    modport sink(input valid, cycle_number, cycle_members, closing_node, found, last,
                 output ready);
endinterface

// ===== hw/rtl/wait_graph_cycle_detector_top.sv =====
// Deadlock detector over a wait-for graph of up to min(MAX_NODES, 32) nodes. An add-edge or
// clear beat gives no result. A detect beat runs a depth-first walk and returns one beat per
// cycle found (found set, cycle_number counting from 1, members as a node mask, closing_node
// the stack top), or a single beat with found clear; last marks the final beat of a run. A
// run scans the roots in order (a root is pushed in the step that scans it), pushes neighbours,
// and pops through the scan that finds no open neighbour, the pop, and the reload of the new
// top from the registered walk stack read (no reload when the stack empties); a neighbour
// already on the stack closes a cycle, whose stack entries are walked with a read and a check
// each before the beat is saved and the top popped, and a last step hands over the final beat.
// The run is longer while the result side stalls. No new request is taken until the run has
// handed its last beat to the output register. node_count must be written only while the
// block is idle; the block itself does not enforce it. reset needs no clearing pass.
`include "wait_graph_cycle_detector_top_defines.svh"

module wait_graph_cycle_detector_top #(
    parameter int MAX_NODES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [wgcd_pkg::CNT_W-1:0] i_cfg_wdata,
    wgcd_req_if.sink                   i_req,
    wgcd_res_if.source                 o_res
);
    import wgcd_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    assign i_req.ready = w_ready;

    wgcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (w_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    wgcd_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_src_node      (i_req.src_node),
        .i_dst_node      (i_req.dst_node),
        .o_res_valid     (o_res.valid),
        .i_res_ready     (o_res.ready),
        .o_cycle_number  (o_res.cycle_number),
        .o_cycle_members (o_res.cycle_members),
        .o_closing_node  (o_res.closing_node),
        .o_found         (o_res.found),
        .o_last          (o_res.last)
    );

    // a held cycle result never outlives its run
    `WGCD_ASSERT(a_idle_no_pend, i_req.ready |-> !w_sts.pend_v, "pending result while idle")
    `WGCD_ASSERT(a_none_is_last, o_res.valid && !o_res.found |-> o_res.last && o_res.cycle_members == '0, "no-cycle beat malformed")
    `WGCD_ASSERT(a_cycle_nonempty, o_res.valid && o_res.found |-> o_res.cycle_members != '0 && o_res.cycle_number != '0, "empty cycle reported")
    `WGCD_ASSERT_RST_LOW(a_rst_pend, w_sts.pend_v, "pending result survives reset")

endmodule

// ===== hw/rtl/wgcd_ctrl.sv =====
module wgcd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic [1:0]    i_req_type,
    output logic          o_req_ready,
    input  wgcd_pkg::t_sts i_sts,
    output wgcd_pkg::t_cmd o_cmd
);
    import wgcd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT,
        S_STEP,
        S_POP,
        S_TOPLD,
        S_WALK_RD,
        S_WALK_CHK,
        S_SAVE,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    unique case (i_req_type)
                        REQ_ADD:   o_cmd.adj_add = 1'b1;
                        REQ_CLEAR: o_cmd.adj_clr = 1'b1;
                        REQ_DETECT: begin
                            o_cmd.run_start = 1'b1;
                            n_state         = S_ROOT;
                        end
                        default: ;
                    endcase
                end
            end
            S_ROOT: begin
                priority if (i_sts.root_done) begin
                    n_state = S_FIN;
                end else if (i_sts.root_fin) begin
                    o_cmd.root_skip = 1'b1;
                end else begin
                    o_cmd.push_root = 1'b1;
                    n_state         = S_STEP;
                end
            end
            S_STEP: begin
                priority if (i_sts.cand_none) begin
                    n_state = S_POP;
                end else if (i_sts.cand_unvis) begin
                    o_cmd.push_nb = 1'b1;
                end else begin
                    // neighbour already on the stack closes a cycle
                    o_cmd.start_walk = 1'b1;
                    n_state          = S_WALK_RD;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = i_sts.depth_one ? S_ROOT : S_TOPLD;
            end
            S_TOPLD: begin
                o_cmd.top_load = 1'b1;
                n_state        = S_STEP;
            end
            S_WALK_RD: begin
                o_cmd.walk_rd = 1'b1;
                n_state       = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                o_cmd.walk_chk = 1'b1;
                n_state        = i_sts.walk_hit ? S_SAVE : S_WALK_RD;
            end
            S_SAVE: begin
                if (i_sts.save_ok) begin
                    o_cmd.save = 1'b1;
                    n_state    = S_POP;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== hw/rtl/wgcd_dp.sv =====
module wgcd_dp #(
    parameter int MAX_NODES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wgcd_pkg::t_cmd              i_cmd,
    output wgcd_pkg::t_sts              o_sts,
    input  logic                        i_cfg_we,
    input  logic [wgcd_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic [wgcd_pkg::NODE_W-1:0] i_src_node,
    input  logic [wgcd_pkg::NODE_W-1:0] i_dst_node,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [wgcd_pkg::CNT_W-1:0]  o_cycle_number,
    output logic [wgcd_pkg::MEMB_W-1:0] o_cycle_members,
    output logic [wgcd_pkg::NODE_W-1:0] o_closing_node,
    output logic                        o_found,
    output logic                        o_last
);
    import wgcd_pkg::*;

    localparam int NL = (MAX_NODES < 32) ? MAX_NODES : 32;
    localparam int IW = $clog2(NL);
    localparam int DW = $clog2(NL + 1);

    logic [CNT_W-1:0]  r_node_count;
    logic [NL-1:0]     r_adj [NL];
    logic [NL-1:0]     r_fin;
    logic [NL-1:0]     r_onstk;
    logic [IW-1:0]     r_stack [NL];
    logic [IW-1:0]     r_rd_data;
    logic [IW-1:0]     r_top;
    logic [IW-1:0]     r_j;
    logic [DW-1:0]     r_depth;
    logic [DW-1:0]     r_root;
    logic [DW-1:0]     r_p;
    logic [NL-1:0]     r_members;
    logic [CNT_W-1:0]  r_cyc;
    logic              r_pend_v;
    logic [CNT_W-1:0]  r_pend_num;
    logic [NL-1:0]     r_pend_memb;
    logic [IW-1:0]     r_pend_close;
    logic              r_out_v;
    logic [CNT_W-1:0]  r_out_num;
    logic [MEMB_W-1:0] r_out_memb;
    logic [NODE_W-1:0] r_out_close;
    logic              r_out_found;
    logic              r_out_last;

    logic [DW-1:0] w_n;
    logic [NL-1:0] w_use;
    logic [NL-1:0] w_row;
    logic [NL-1:0] w_low;
    logic [IW-1:0] w_j;
    logic          w_edge_ok;
    logic          w_out_free;
    logic          w_rd_en;
    logic [DW-1:0] w_rd_addr;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_addr;
    logic [IW-1:0] w_wr_data;

    always_comb begin
        w_n = (r_node_count > CNT_W'(NL)) ? DW'(NL) : r_node_count[DW-1:0];
        for (int k = 0; k < NL; k++) begin
            w_use[k] = (DW'(k) < w_n);
        end
        w_edge_ok = (CNT_W'(i_src_node) < CNT_W'(w_n)) && (CNT_W'(i_dst_node) < CNT_W'(w_n));
        // first neighbour not yet finished, lowest index wins
        w_row = r_adj[r_top] & w_use & ~r_fin;
        w_low = w_row & (~w_row + NL'(1));
        w_j   = '0;
        for (int k = 0; k < NL; k++) begin
            if (w_low[k]) begin
                w_j = w_j | IW'(k);
            end
        end
        w_out_free = !r_out_v || i_res_ready;

        w_rd_en   = (i_cmd.pop && (r_depth != DW'(1))) || i_cmd.walk_rd;
        w_rd_addr = i_cmd.walk_rd ? (r_p - DW'(1)) : (r_depth - DW'(2));
        w_wr_en   = i_cmd.push_root || i_cmd.push_nb;
        w_wr_addr = i_cmd.push_root ? '0 : r_depth[IW-1:0];
        w_wr_data = i_cmd.push_root ? r_root[IW-1:0] : w_j;
    end

    always_comb begin
        o_sts            = '0;
        o_sts.root_done  = (r_root >= w_n);
        o_sts.root_fin   = r_fin[r_root[IW-1:0]];
        o_sts.cand_none  = (w_row == '0);
        o_sts.cand_unvis = !r_onstk[w_j];
        o_sts.walk_hit   = (r_rd_data == r_j);
        o_sts.depth_one  = (r_depth == DW'(1));
        o_sts.out_free   = w_out_free;
        o_sts.save_ok    = !r_pend_v || w_out_free;
        o_sts.pend_v     = r_pend_v;
    end

    // walk stack memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_stack[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_stack[w_rd_addr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            for (int r = 0; r < NL; r++) begin
                r_adj[r] <= '0;
            end
            r_fin    <= '0;
            r_onstk  <= '0;
            r_depth  <= '0;
            r_root   <= '0;
            r_cyc    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (i_cmd.adj_add && w_edge_ok) begin
                r_adj[i_src_node[IW-1:0]][i_dst_node[IW-1:0]] <= 1'b1;
            end
            if (i_cmd.adj_clr) begin
                for (int r = 0; r < NL; r++) begin
                    r_adj[r] <= '0;
                end
            end
            if (i_cmd.run_start) begin
                r_fin   <= '0;
                r_onstk <= '0;
                r_depth <= '0;
                r_root  <= '0;
                r_cyc   <= '0;
            end
            if (i_cmd.root_skip) begin
                r_root <= r_root + DW'(1);
            end
            if (i_cmd.push_root) begin
                r_onstk[r_root[IW-1:0]] <= 1'b1;
                r_depth                 <= DW'(1);
                r_root                  <= r_root + DW'(1);
            end
            if (i_cmd.push_nb) begin
                r_onstk[w_j] <= 1'b1;
                r_depth      <= r_depth + DW'(1);
            end
            if (i_cmd.pop) begin
                r_fin[r_top]   <= 1'b1;
                r_onstk[r_top] <= 1'b0;
                r_depth        <= r_depth - DW'(1);
            end
            if (i_cmd.save) begin
                r_cyc    <= r_cyc + CNT_W'(1);
                r_pend_v <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_pend_v <= 1'b0;
            end
            priority if ((i_cmd.save && r_pend_v) || i_cmd.finish) begin
                r_out_v <= 1'b1;
            end else if (i_res_ready) begin
                r_out_v <= 1'b0;
            end else begin
                r_out_v <= r_out_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_root) begin
            r_top <= r_root[IW-1:0];
        end else if (i_cmd.push_nb) begin
            r_top <= w_j;
        end else if (i_cmd.top_load) begin
            r_top <= r_rd_data;
        end
        if (i_cmd.start_walk) begin
            r_j       <= w_j;
            r_p       <= r_depth;
            r_members <= '0;
        end
        if (i_cmd.walk_rd) begin
            r_p <= r_p - DW'(1);
        end
        if (i_cmd.walk_chk) begin
            r_members[r_rd_data] <= 1'b1;
        end
        if (i_cmd.save) begin
            r_pend_num   <= r_cyc + CNT_W'(1);
            r_pend_memb  <= r_members;
            r_pend_close <= r_top;
        end
        // older pending cycle moves out; it is the final beat only when the run finishes
        if ((i_cmd.save && r_pend_v) || (i_cmd.finish && r_pend_v)) begin
            r_out_num   <= r_pend_num;
            r_out_memb  <= MEMB_W'(r_pend_memb);
            r_out_close <= NODE_W'(r_pend_close);
            r_out_found <= 1'b1;
            r_out_last  <= i_cmd.finish;
        end else if (i_cmd.finish) begin
            r_out_num   <= '0;
            r_out_memb  <= '0;
            r_out_close <= '0;
            r_out_found <= 1'b0;
            r_out_last  <= 1'b1;
        end
    end

    assign o_res_valid     = r_out_v;
    assign o_cycle_number  = r_out_num;
    assign o_cycle_members = r_out_memb;
    assign o_closing_node  = r_out_close;
    assign o_found         = r_out_found;
    assign o_last          = r_out_last;

endmodule
